/* rtl/core/wsdf_pkg.sv */
// ----------------------------------------------------------------------------
// wsdf_pkg - shared types for the WebSocket frame deframer
// Length codes, parse phase codes and the parser-to-output-stage result word.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdf_pkg;

	// Length codes carried in header byte 1
	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;

	// Extended length byte counts, as seen by a 3-bit wrapping counter
	localparam logic [2:0] LEN16_BYTES = 3'd2;
	localparam logic [2:0] LEN64_BYTES = 3'd0;  // eight bytes wrap to zero
	localparam logic [2:0] MASK_BYTES  = 3'd4;

	// Parse phase
	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// One payload result from the parser
	typedef struct packed {
		logic       valid;
		logic [7:0] payload_byte;
		logic [3:0] frame_opcode;
		logic       fin_flag;
		logic       was_masked;
		logic       frame_last;
		logic       message_done;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/wsdf_parser.sv */
// ----------------------------------------------------------------------------
// wsdf_parser - frame header parser and payload unmasker
// Takes one stream byte per enabled cycle, tracks the header fields and the
// remaining length, and returns the unmasked payload byte as a result.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdf_parser (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,          // a byte is taken this cycle
	input  wire  [7:0]          in_byte,
	input  wire                 in_restart,
	output wsdf_pkg::result_t   res
);

	wsdf_pkg::phase_t phase_q, phase_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [63:0] rem_q, rem_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  mpos_q, mpos_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        fin_q, fin_d;
	logic        mflag_q, mflag_d;
	logic        len64_q, len64_d;

	logic [2:0]  cnt_inc;
	logic [63:0] ext_len;
	logic        rem_zero;
	logic        rem_last;
	logic [7:0]  key_byte;
	wsdf_pkg::phase_t cur_phase;

	assign cnt_inc  = cnt_q + 3'd1;
	assign ext_len  = {rem_q[55:0], in_byte};
	assign rem_zero = (rem_q == 64'd0);
	assign rem_last = (rem_q[63:1] == 63'd0);
	assign cur_phase = in_restart ? wsdf_pkg::PH_HDR0 : phase_q;

	// Select mask key byte, first key byte in the top bits
	always_comb begin
		unique case (mpos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// Next state
	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		key_d    = key_q;
		mpos_d   = mpos_q;
		opcode_d = opcode_q;
		fin_d    = fin_q;
		mflag_d  = mflag_q;
		len64_d  = len64_q;
		unique case (cur_phase)
			wsdf_pkg::PH_HDR1: begin
				mflag_d = in_byte[7];
				cnt_d   = 3'd0;
				mpos_d  = 2'd0;
				if (in_byte[6:0] == wsdf_pkg::LEN16_CODE) begin
					rem_d   = 64'd0;
					len64_d = 1'b0;
					phase_d = wsdf_pkg::PH_EXTLEN;
				end else if (in_byte[6:0] == wsdf_pkg::LEN64_CODE) begin
					rem_d   = 64'd0;
					len64_d = 1'b1;
					phase_d = wsdf_pkg::PH_EXTLEN;
				end else begin
					rem_d = {57'd0, in_byte[6:0]};
					if (in_byte[7]) begin
						key_d   = 32'd0;
						phase_d = wsdf_pkg::PH_MASK;
					end else if (in_byte[6:0] == 7'd0) begin
						phase_d = wsdf_pkg::PH_HDR0;
					end else begin
						phase_d = wsdf_pkg::PH_PAYLOAD;
					end
				end
			end
			wsdf_pkg::PH_EXTLEN: begin
				// Shift in big-endian length bytes
				rem_d = ext_len;
				cnt_d = cnt_inc;
				if (cnt_inc == (len64_q ? wsdf_pkg::LEN64_BYTES : wsdf_pkg::LEN16_BYTES)) begin
					cnt_d  = 3'd0;
					mpos_d = 2'd0;
					if (mflag_q) begin
						key_d   = 32'd0;
						phase_d = wsdf_pkg::PH_MASK;
					end else if (ext_len == 64'd0) begin
						phase_d = wsdf_pkg::PH_HDR0;
					end else begin
						phase_d = wsdf_pkg::PH_PAYLOAD;
					end
				end
			end
			wsdf_pkg::PH_MASK: begin
				key_d = {key_q[23:0], in_byte};
				cnt_d = cnt_inc;
				if (cnt_inc >= wsdf_pkg::MASK_BYTES) begin
					cnt_d   = 3'd0;
					mpos_d  = 2'd0;
					phase_d = rem_zero ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_PAYLOAD;
				end
			end
			wsdf_pkg::PH_PAYLOAD: begin
				mpos_d = mpos_q + 2'd1;
				rem_d  = rem_q - 64'd1;
				if (rem_last) begin
					rem_d   = 64'd0;
					phase_d = wsdf_pkg::PH_HDR0;
				end
			end
			default: begin
				// Header byte zero, also on restart and unused codes
				fin_d    = in_byte[7];
				opcode_d = in_byte[3:0];
				cnt_d    = 3'd0;
				phase_d  = wsdf_pkg::PH_HDR1;
			end
		endcase
	end

	// Result for a payload byte
	always_comb begin
		res.valid        = (cur_phase == wsdf_pkg::PH_PAYLOAD);
		res.payload_byte = mflag_q ? (in_byte ^ key_byte) : in_byte;
		res.frame_opcode = opcode_q;
		res.fin_flag     = fin_q;
		res.was_masked   = mflag_q;
		res.frame_last   = rem_last;
		res.message_done = rem_last & fin_q;
	end

	// Advance parser state on each taken byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsdf_pkg::PH_HDR0;
			cnt_q    <= 3'd0;
			rem_q    <= 64'd0;
			key_q    <= 32'd0;
			mpos_q   <= 2'd0;
			opcode_q <= 4'd0;
			fin_q    <= 1'b0;
			mflag_q  <= 1'b0;
			len64_q  <= 1'b0;
		end else if (en) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			rem_q    <= rem_d;
			key_q    <= key_d;
			mpos_q   <= mpos_d;
			opcode_q <= opcode_d;
			fin_q    <= fin_d;
			mflag_q  <= mflag_d;
			len64_q  <= len64_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer - WebSocket receive-side frame deframer
// Strips frame headers from a byte stream and unmasks the payload bytes.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock on the slave side while the master side keeps
// up, and delivers one word per payload byte on the master side, with opcode,
// FIN, mask and end-of-frame marks. Header, length and mask key bytes give no
// output word. A byte flows through an input register, the parser logic and an
// output register: an accepted byte is held in the input register, and its
// word is loaded into the output register once that register is free.
// Setting tuser on a byte forces it to be taken as the first header byte of a
// new frame, dropping any frame in progress. Zero-length frames consume their
// header and mask bytes and give no output.
`default_nettype none

module websocket_frame_deframer (
	input  wire        clk,
	input  wire        arst_n,
	// slave side
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [7:0] s_axis_tdata,   // [7:0] stream_byte
	input  wire  [0:0] s_axis_tuser,   // [0] restart
	// master side
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
	output logic [6:0] m_axis_tuser,   // [3:0] frame_opcode, [4] fin_flag,
	                                   // [5] was_masked, [6] message_done
	output logic       m_axis_tlast    // frame_last
);

	logic              in_valid_s1;
	logic [7:0]        in_byte_s1;
	logic              in_restart_s1;
	logic              out_free;
	logic              adv;
	wsdf_pkg::result_t res;
	logic              res_valid_s2;
	wsdf_pkg::result_t res_s2;

	// Output register can take a new word
	assign out_free      = !res_valid_s2 || m_axis_tready;
	assign adv           = in_valid_s1 && out_free;
	assign s_axis_tready = !in_valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_byte_s1    <= s_axis_tdata;
			in_restart_s1 <= s_axis_tuser[0];
		end
	end

	wsdf_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_byte    (in_byte_s1),
		.in_restart (in_restart_s1),
		.res        (res)
	);

	// Output register, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (out_free) begin
			res_valid_s2 <= adv && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv && res.valid) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = res_valid_s2;
	assign m_axis_tdata  = res_s2.payload_byte;
	assign m_axis_tuser  = {res_s2.message_done, res_s2.was_masked, res_s2.fin_flag,
	                        res_s2.frame_opcode};
	assign m_axis_tlast  = res_s2.frame_last;

endmodule

`default_nettype wire

/* rtl/core/wsdf_checker.sv */
// ----------------------------------------------------------------------------
// wsdf_checker - port-level checks for the deframer
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdf_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_axis_tvalid,
	input wire       s_axis_tready,
	input wire       m_axis_tvalid,
	input wire       m_axis_tready,
	input wire [7:0] m_axis_tdata,
	input wire [6:0] m_axis_tuser,
	input wire       m_axis_tlast
);

	// Hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// Message completion only on the last word of a FIN frame
	a_done_mark: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[6] |-> m_axis_tlast && m_axis_tuser[4])
		else $error("message_done without frame_last and fin_flag");

	// Input side never stalls while the output side drains
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output ready");

	// An idle block with no input does not then show an output word
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && !s_axis_tvalid ##1 !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("output word without input");

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
